// ===== design/fcct_pkg.sv =====
// Package with shared constants, types and command structs for the fuzzy concept closure test.
package fcct_pkg;

	localparam int MAX_OBJECTS    = 64;
	localparam int MAX_ATTRIBUTES = 16;
	localparam int ATTR_LIMIT     = (MAX_ATTRIBUTES < 16) ? MAX_ATTRIBUTES : 16;
	localparam int GRADE_W        = 8;
	localparam int ROW_W          = $clog2(MAX_OBJECTS);
	localparam int COL_W          = $clog2(MAX_ATTRIBUTES);
	localparam int OBJ_CNT_W      = 7;
	localparam int ATTR_CNT_W     = 5;
	localparam int MASK_W         = 16;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;

	// Function codes of an input transaction.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TEST  = 1'b1;

	// Register indexes, taken from the word address.
	localparam logic REG_OBJECT_COUNT    = 1'b0;
	localparam logic REG_ATTRIBUTE_COUNT = 1'b1;

	typedef logic [GRADE_W-1:0] grade_t;
	typedef grade_t [MAX_ATTRIBUTES-1:0] row_t;

	typedef struct packed {
		logic              func;
		logic [5:0]        object_index;
		logic [3:0]        attribute_index;
		logic [7:0]        grade;
		logic [MASK_W-1:0] attribute_mask;
	} in_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] closure_mask;
		logic              is_concept;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             write_en;
		logic             load_test;
		logic             rd_en;
		logic [ROW_W-1:0] rd_row;
		logic             finish;
	} cmd_t;

endpackage

// ===== design/fcct_regs.sv =====
// Configuration registers with APB-style access and saturated effective counts.
module fcct_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [fcct_pkg::ADDR_W-1:0]      paddr,
	input  logic [fcct_pkg::DATA_W-1:0]      pwdata,
	output logic [fcct_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	output logic [fcct_pkg::OBJ_CNT_W-1:0]   n_obj,
	output logic [fcct_pkg::ATTR_CNT_W-1:0]  n_attr
);

	logic [fcct_pkg::OBJ_CNT_W-1:0]  object_count_q;
	logic [fcct_pkg::ATTR_CNT_W-1:0] attribute_count_q;
	logic                            wr_fire;
	logic                            reg_sel;

	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_count_q    <= fcct_pkg::OBJ_CNT_W'(64);
			attribute_count_q <= fcct_pkg::ATTR_CNT_W'(16);
		end else if (wr_fire) begin
			unique case (reg_sel)
				fcct_pkg::REG_OBJECT_COUNT:
					object_count_q <= pwdata[fcct_pkg::OBJ_CNT_W-1:0];
				fcct_pkg::REG_ATTRIBUTE_COUNT:
					attribute_count_q <= pwdata[fcct_pkg::ATTR_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (reg_sel)
			fcct_pkg::REG_OBJECT_COUNT:
				prdata = fcct_pkg::DATA_W'(object_count_q);
			default:
				prdata = fcct_pkg::DATA_W'(attribute_count_q);
		endcase
	end

	// Counts above the store size saturate.
	assign n_obj = (32'(object_count_q) > fcct_pkg::MAX_OBJECTS) ?
		fcct_pkg::OBJ_CNT_W'(fcct_pkg::MAX_OBJECTS) : object_count_q;
	assign n_attr = (32'(attribute_count_q) > fcct_pkg::ATTR_LIMIT) ?
		fcct_pkg::ATTR_CNT_W'(fcct_pkg::ATTR_LIMIT) : attribute_count_q;

endmodule

// ===== design/fcct_ctrl.sv =====
// Controller state machine that sequences grade writes and the row sweep of a test.
module fcct_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            func,
	input  logic [fcct_pkg::OBJ_CNT_W-1:0]  n_obj,
	output logic                            busy,
	output fcct_pkg::cmd_t                  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic                        rd_en_q;
	logic [fcct_pkg::ROW_W-1:0]  rd_row_q;
	logic                        finish_q;
	logic                        drain_q;
	logic                        accept;
	logic                        last_row;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign last_row = ({1'b0, rd_row_q} == (n_obj - fcct_pkg::OBJ_CNT_W'(1)));

	// Commands: writes and test loads follow the accepted transaction directly.
	always_comb begin
		cmd.write_en  = accept && (func == fcct_pkg::FUNC_WRITE);
		cmd.load_test = accept && (func == fcct_pkg::FUNC_TEST);
		cmd.rd_en     = rd_en_q;
		cmd.rd_row    = rd_row_q;
		cmd.finish    = finish_q;
	end

	// State and registered commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_en_q  <= 1'b0;
			rd_row_q <= '0;
			finish_q <= 1'b0;
			drain_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (func == fcct_pkg::FUNC_TEST)) begin
						if (n_obj == '0) begin
							state_q  <= ST_FINISH;
							finish_q <= 1'b1;
						end else begin
							state_q  <= ST_ISSUE;
							rd_en_q  <= 1'b1;
							rd_row_q <= '0;
						end
					end
				end
				ST_ISSUE: begin
					if (last_row) begin
						state_q <= ST_DRAIN;
						rd_en_q <= 1'b0;
						drain_q <= 1'b0;
					end else begin
						rd_row_q <= rd_row_q + fcct_pkg::ROW_W'(1);
					end
				end
				ST_DRAIN: begin
					// The drain state lets the last row pass the max and compare stages.
					if (drain_q) begin
						state_q  <= ST_FINISH;
						finish_q <= 1'b1;
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					state_q  <= ST_IDLE;
					finish_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/fcct_datapath.sv =====
// Datapath with the grade memory, the row maximum stage and the closure register.
module fcct_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fcct_pkg::cmd_t                   cmd,
	input  fcct_pkg::in_item_t               item,
	input  logic [fcct_pkg::ATTR_CNT_W-1:0]  n_attr,
	output logic                             done,
	output fcct_pkg::out_item_t              result
);

	// Grade memory: one row of grades per object, written one grade lane at a time.
	fcct_pkg::row_t mem [fcct_pkg::MAX_OBJECTS];

	fcct_pkg::row_t                 rdata_s1;
	logic                           v_s1;
	fcct_pkg::row_t                 row_s2;
	fcct_pkg::grade_t               max_s2;
	logic                           v_s2;
	logic [fcct_pkg::MASK_W-1:0]    subset_q;
	logic [fcct_pkg::MASK_W-1:0]    closure_q;
	logic [fcct_pkg::MASK_W-1:0]    use_mask;
	logic                           wr_in_range;
	fcct_pkg::out_item_t            result_q;
	logic                           done_q;

	fcct_pkg::grade_t lvl0 [16];
	fcct_pkg::grade_t lvl1 [8];
	fcct_pkg::grade_t lvl2 [4];
	fcct_pkg::grade_t lvl3 [2];
	fcct_pkg::grade_t row_max;
	logic [fcct_pkg::MASK_W-1:0] clear_bits;

	assign wr_in_range = (32'(item.object_index) < fcct_pkg::MAX_OBJECTS) &&
		(32'(item.attribute_index) < fcct_pkg::MAX_ATTRIBUTES);

	// Attributes in use.
	always_comb begin
		for (int a = 0; a < fcct_pkg::MASK_W; a++) begin
			use_mask[a] = (32'(n_attr) > a);
		end
	end

	// Memory write and registered row read.
	always_ff @(posedge clk) begin
		if (cmd.write_en && wr_in_range) begin
			mem[item.object_index[fcct_pkg::ROW_W-1:0]]
				[item.attribute_index[fcct_pkg::COL_W-1:0]] <= item.grade;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[cmd.rd_row];
		end
	end

	// Maximum over the chosen grades of a row, as a four-level compare tree.
	always_comb begin
		for (int a = 0; a < 16; a++) begin
			lvl0[a] = (a < fcct_pkg::MAX_ATTRIBUTES && subset_q[a]) ?
				rdata_s1[a % fcct_pkg::MAX_ATTRIBUTES] : '0;
		end
		for (int i = 0; i < 8; i++) begin
			lvl1[i] = (lvl0[2*i] > lvl0[2*i+1]) ? lvl0[2*i] : lvl0[2*i+1];
		end
		for (int i = 0; i < 4; i++) begin
			lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
		end
		for (int i = 0; i < 2; i++) begin
			lvl3[i] = (lvl2[2*i] > lvl2[2*i+1]) ? lvl2[2*i] : lvl2[2*i+1];
		end
		row_max = (lvl3[0] > lvl3[1]) ? lvl3[0] : lvl3[1];
	end

	// Attributes whose grade exceeds the row maximum leave the closure.
	always_comb begin
		clear_bits = '0;
		for (int a = 0; a < fcct_pkg::MAX_ATTRIBUTES; a++) begin
			clear_bits[a] = (row_s2[a] > max_s2);
		end
	end

	// Stage registers for the row maximum.
	always_ff @(posedge clk) begin
		row_s2 <= rdata_s1;
		max_s2 <= row_max;
	end

	// Pipeline valids, closure accumulation and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.rd_en;
			v_s2   <= v_s1;
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_test) begin
			subset_q  <= item.attribute_mask & use_mask;
			closure_q <= use_mask;
		end else if (v_s2) begin
			closure_q <= closure_q & ~clear_bits;
		end
		if (cmd.finish) begin
			result_q.closure_mask <= closure_q;
			result_q.is_concept   <= (closure_q == subset_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== design/fuzzy_concept_closure_test.sv =====
// A grade write is stored at its accepting edge. A test reads one row of grades per cycle
// from the single read port of the grade memory and raises done once the last row has
// passed the max and compare stages (without a row sweep when object_count is zero); a new
// transaction is taken only when busy is low again, which it is in the cycle done shows.
// Reset clears the controller and the registers to 64 objects and 16 attributes.
// The grade memory is not cleared; the receiver cannot stall the done strobe.
module fuzzy_concept_closure_test (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  fcct_pkg::in_item_t              item,
	output logic                            done,
	output fcct_pkg::out_item_t             result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcct_pkg::ADDR_W-1:0]     paddr,
	input  logic [fcct_pkg::DATA_W-1:0]     pwdata,
	output logic [fcct_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	logic [fcct_pkg::OBJ_CNT_W-1:0]  n_obj;
	logic [fcct_pkg::ATTR_CNT_W-1:0] n_attr;
	fcct_pkg::cmd_t                  cmd;

	// Configuration registers.
	fcct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.n_obj   (n_obj),
		.n_attr  (n_attr)
	);

	// Sequencer.
	fcct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.n_obj  (n_obj),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Grade memory and closure logic.
	fcct_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.n_attr (n_attr),
		.done   (done),
		.result (result)
	);

endmodule

// ===== design/fcct_checker.sv =====
// Port-level checker for the fuzzy concept closure test, bound to the top level.
module fcct_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input fcct_pkg::in_item_t           item,
	input logic                         done,
	input fcct_pkg::out_item_t          result,
	input logic                         pready
);

	// A result ends a test, so the block is free when it shows.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// A result always follows a busy cycle of its test transaction.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result strobe without a test in progress");

	// An accepted test occupies the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.func == fcct_pkg::FUNC_TEST) |=> busy)
		else $error("test transaction did not start a sweep");

	// A grade write leaves the block free in the next cycle and gives no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.func == fcct_pkg::FUNC_WRITE) |=> (!busy && !done))
		else $error("write transaction held the block or produced a result");

	// The register port never inserts wait states.
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind fuzzy_concept_closure_test fcct_checker u_chk (.*);
